[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that expr holds at every rising edge outside reset.
`define AST_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Checks that cons holds in the same cycle as ante.
`define AST_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that cons holds in the cycle after ante.
`define AST_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/rct_pkg.sv]
`timescale 1ns / 1ps

package rct_pkg;

   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_VT     = 8'h0B;
   localparam logic [7:0] CHAR_FF     = 8'h0C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_9      = 8'h39;

   // The accumulator saturates just above the largest legal magnitude.
   localparam logic [31:0] NUM_CAP     = 32'h8000_0001;
   localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MAX_MAG = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] accum;
      logic        seen;
      logic        stopped;
      logic        neg;
      logic        sign_seen;
      logic        cr_seen;
   } num_state_type;

   typedef struct packed {
      logic done;
      logic bad;
      logic negative;
      logic zero;
   } num_status_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        token_start;
      logic        token_end;
      logic [15:0] token_index;
      logic        message_done;
      logic [15:0] token_count;
      logic        malformed;
      logic        incomplete_token;
   } rsp_word_type;

   function automatic logic is_space(logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
             (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
   endfunction

endpackage

[rtl/core/rct_num_field.sv]
`timescale 1ns / 1ps

module rct_num_field import rct_pkg::*; (
   input  num_state_type  num_i,
   input  logic [7:0]     data_i,
   output num_state_type  num_o,
   output num_status_type status_o
);

   function automatic num_state_type feed(num_state_type s, logic [7:0] c);
      num_state_type r;
      logic [35:0]   v;
      r = s;
      v = ({4'd0, s.accum} << 3) + ({4'd0, s.accum} << 1) + {28'd0, 8'(c - CHAR_0)};
      if (!s.stopped) begin
         if ((c >= CHAR_0) && (c <= CHAR_9)) begin
            r.accum = (v > {4'd0, NUM_CAP}) ? NUM_CAP : v[31:0];
            r.seen  = 1'b1;
         end else if (!s.seen && !s.sign_seen && is_space(c)) begin
            r.stopped = 1'b0;
         end else if (!s.seen && !s.sign_seen && ((c == CHAR_PLUS) || (c == CHAR_MINUS))) begin
            r.sign_seen = 1'b1;
            if (c == CHAR_MINUS) begin
               r.neg = 1'b1;
            end
         end else begin
            r.stopped = 1'b1;
         end
      end
      return r;
   endfunction

   num_state_type after_cr;

   assign status_o.done = num_i.cr_seen && (data_i == CHAR_LF);

   // A pending CR that is not followed by LF counts as a field byte.
   always_comb begin
      after_cr         = num_i.cr_seen ? feed(num_i, CHAR_CR) : num_i;
      after_cr.cr_seen = 1'b0;
      if (status_o.done) begin
         num_o = after_cr;
         num_o.accum = num_i.accum;
      end else if (data_i == CHAR_CR) begin
         num_o = after_cr;
         num_o.cr_seen = 1'b1;
      end else begin
         num_o = feed(after_cr, data_i);
      end
   end

   assign status_o.bad      = !num_i.seen ||
                              (num_i.neg ? (num_i.accum > NEG_MAX_MAG) : (num_i.accum > POS_MAX));
   assign status_o.negative = num_i.neg && (num_i.accum != '0);
   assign status_o.zero     = (num_i.accum == '0);

endmodule

[rtl/core/resp_command_tokenizer.sv]
`timescale 1ns / 1ps
// Accepted words and their results are registered. Throughput: one input word per
// cycle unless rsp_stall holds a result; one register pair (input, result) with a
// single step of byte decode and a multiply-by-ten accumulate between them.
// Words that cause no result leave nothing on the result side.
// Reset is synchronous and active high; it returns the parser to wait for a new message.
`include "assert_macros.svh"

module resp_command_tokenizer import rct_pkg::*; #(
   parameter int unsigned MAX_ELEMENTS    = 65535,
   parameter int unsigned MAX_BULK_LENGTH = 2147483647
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_token_start,
   output logic        rsp_token_end,
   output logic [15:0] rsp_token_index,
   output logic        rsp_message_done,
   output logic [15:0] rsp_token_count,
   output logic        rsp_malformed,
   output logic        rsp_incomplete_token
);

   localparam int unsigned ELEM_LIMIT = (MAX_ELEMENTS < 65535) ? MAX_ELEMENTS : 65535;
   localparam int EL_W = $clog2(ELEM_LIMIT + 1);
   localparam int PL_W = $clog2(longint'(MAX_BULK_LENGTH) + 64'd1);
   localparam logic [1:0] TRAILER_LEN = 2'd2;

   typedef enum logic [1:0] {
      MODE_AWAIT,
      MODE_WS,
      MODE_RESP,
      MODE_STOP
   } mode_type;

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_DOLLAR,
      PH_LENGTH,
      PH_PAYLOAD,
      PH_TRAILER
   } phase_type;

   mode_type       mode_ff, mode_in;
   phase_type      phase_ff, phase_in;
   logic [EL_W-1:0] elements_left_ff, elements_left_in;
   num_state_type  num_ff, num_in;
   logic [PL_W-1:0] payload_left_ff, payload_left_in;
   logic [1:0]     trailer_left_ff, trailer_left_in;
   logic [15:0]    cur_index_ff, cur_index_in;
   logic           in_token_ff, in_token_in;
   logic           bad_number_ff, bad_number_in;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     data_ff;
   logic           last_ff;
   logic           out_valid_ff, out_valid_in;
   rsp_word_type   res_ff, res_in;
   logic           have_res;

   logic           advance;
   logic           req_accept;
   num_state_type  num_next;
   num_status_type num_status;
   logic [15:0]    index_bump;
   logic [EL_W-1:0] elements_dec;
   logic [PL_W-1:0] payload_dec;
   logic [1:0]     trailer_dec;

   rct_num_field u_num (
      .num_i    (num_ff),
      .data_i   (data_ff),
      .num_o    (num_next),
      .status_o (num_status)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign index_bump   = (cur_index_ff == 16'hFFFF) ? cur_index_ff : cur_index_ff + 16'd1;
   assign elements_dec = (elements_left_ff != '0) ? elements_left_ff - EL_W'(1) : '0;
   assign payload_dec  = (payload_left_ff != '0) ? payload_left_ff - PL_W'(1) : '0;
   assign trailer_dec  = (trailer_left_ff != '0) ? trailer_left_ff - 2'd1 : '0;

   always_comb begin
      mode_in          = mode_ff;
      phase_in         = phase_ff;
      elements_left_in = elements_left_ff;
      num_in           = num_ff;
      payload_left_in  = payload_left_ff;
      trailer_left_in  = trailer_left_ff;
      cur_index_in     = cur_index_ff;
      in_token_in      = in_token_ff;
      bad_number_in    = bad_number_ff;
      res_in           = '0;
      have_res         = 1'b0;

      if ((mode_ff == MODE_AWAIT) && (data_ff == CHAR_STAR)) begin
         mode_in  = MODE_RESP;
         phase_in = PH_COUNT;
         num_in   = '0;
      end else if ((mode_ff == MODE_AWAIT) || (mode_ff == MODE_WS)) begin
         mode_in = MODE_WS;
         if (is_space(data_ff)) begin
            if (in_token_ff) begin
               have_res           = 1'b1;
               res_in.token_end   = 1'b1;
               res_in.token_index = cur_index_ff;
               cur_index_in       = index_bump;
               in_token_in        = 1'b0;
            end
         end else begin
            have_res           = 1'b1;
            res_in.out_byte    = data_ff;
            res_in.byte_valid  = 1'b1;
            res_in.token_start = !in_token_ff;
            res_in.token_end   = last_ff;
            res_in.token_index = cur_index_ff;
            in_token_in        = 1'b1;
            if (last_ff) begin
               cur_index_in = index_bump;
               in_token_in  = 1'b0;
            end
         end
      end else if (mode_ff == MODE_RESP) begin
         unique case (phase_ff)
            PH_COUNT: begin
               num_in = num_next;
               if (num_status.done) begin
                  if (num_status.bad) begin
                     bad_number_in = 1'b1;
                     mode_in       = MODE_STOP;
                  end else if (num_status.negative || num_status.zero) begin
                     mode_in = MODE_STOP;
                  end else begin
                     elements_left_in = (num_ff.accum > 32'(ELEM_LIMIT)) ?
                                        EL_W'(ELEM_LIMIT) : num_ff.accum[EL_W-1:0];
                     phase_in = PH_DOLLAR;
                  end
               end
            end
            PH_DOLLAR: begin
               if (data_ff == CHAR_DOLLAR) begin
                  num_in   = '0;
                  phase_in = PH_LENGTH;
               end else begin
                  mode_in = MODE_STOP;
               end
            end
            PH_LENGTH: begin
               num_in = num_next;
               if (num_status.done) begin
                  if (num_status.bad ||
                      (!num_status.negative && (num_ff.accum > 32'(MAX_BULK_LENGTH)))) begin
                     bad_number_in = 1'b1;
                     mode_in       = MODE_STOP;
                  end else if (num_status.negative) begin
                     mode_in = MODE_STOP;
                  end else if (num_status.zero) begin
                     // An empty bulk string is a byteless token of its own.
                     have_res           = 1'b1;
                     res_in.token_start = 1'b1;
                     res_in.token_end   = 1'b1;
                     res_in.token_index = cur_index_ff;
                     cur_index_in       = index_bump;
                     in_token_in        = 1'b0;
                     elements_left_in   = elements_dec;
                     if (elements_dec == '0) begin
                        mode_in = MODE_STOP;
                     end else begin
                        phase_in        = PH_TRAILER;
                        trailer_left_in = TRAILER_LEN;
                     end
                  end else begin
                     payload_left_in = num_ff.accum[PL_W-1:0];
                     in_token_in     = 1'b0;
                     phase_in        = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               payload_left_in    = payload_dec;
               have_res           = 1'b1;
               res_in.out_byte    = data_ff;
               res_in.byte_valid  = 1'b1;
               res_in.token_start = !in_token_ff;
               res_in.token_end   = (payload_dec == '0);
               res_in.token_index = cur_index_ff;
               in_token_in        = 1'b1;
               if (payload_dec == '0) begin
                  cur_index_in     = index_bump;
                  in_token_in      = 1'b0;
                  elements_left_in = elements_dec;
                  if (elements_dec == '0) begin
                     mode_in = MODE_STOP;
                  end else begin
                     phase_in        = PH_TRAILER;
                     trailer_left_in = TRAILER_LEN;
                  end
               end
            end
            PH_TRAILER: begin
               trailer_left_in = trailer_dec;
               if (trailer_dec == '0) begin
                  phase_in = PH_DOLLAR;
               end
            end
            default: begin
               mode_in = MODE_STOP;
            end
         endcase
      end

      if (last_ff) begin
         have_res                = 1'b1;
         res_in.message_done     = 1'b1;
         res_in.token_count      = cur_index_in;
         res_in.malformed        = bad_number_in;
         res_in.incomplete_token = (mode_in == MODE_RESP) && in_token_in;
         mode_in          = MODE_AWAIT;
         phase_in         = PH_COUNT;
         elements_left_in = '0;
         num_in           = '0;
         payload_left_in  = '0;
         trailer_left_in  = '0;
         cur_index_in     = '0;
         in_token_in      = 1'b0;
         bad_number_in    = 1'b0;
      end
   end

   always_comb begin
      if (advance) begin
         in_valid_in = req_accept;
      end else begin
         in_valid_in = in_valid_ff || req_accept;
      end
      if (advance) begin
         out_valid_in = have_res;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_AWAIT;
         phase_ff         <= PH_COUNT;
         elements_left_ff <= '0;
         num_ff           <= '0;
         payload_left_ff  <= '0;
         trailer_left_ff  <= '0;
         cur_index_ff     <= '0;
         in_token_ff      <= 1'b0;
         bad_number_ff    <= 1'b0;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mode_ff          <= mode_in;
            phase_ff         <= phase_in;
            elements_left_ff <= elements_left_in;
            num_ff           <= num_in;
            payload_left_ff  <= payload_left_in;
            trailer_left_ff  <= trailer_left_in;
            cur_index_ff     <= cur_index_in;
            in_token_ff      <= in_token_in;
            bad_number_ff    <= bad_number_in;
         end
      end
      if (req_accept) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
      if (advance && have_res) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_out_byte         = res_ff.out_byte;
   assign rsp_byte_valid       = res_ff.byte_valid;
   assign rsp_token_start      = res_ff.token_start;
   assign rsp_token_end        = res_ff.token_end;
   assign rsp_token_index      = res_ff.token_index;
   assign rsp_message_done     = res_ff.message_done;
   assign rsp_token_count      = res_ff.token_count;
   assign rsp_malformed        = res_ff.malformed;
   assign rsp_incomplete_token = res_ff.incomplete_token;

   `AST_NEXT(a_last_clears, advance && last_ff,
      (mode_ff == MODE_AWAIT) && (cur_index_ff == '0) && !bad_number_ff,
      "parser state not cleared after the last word of a message")
   `AST_IMPLY(a_summary_only_at_end, rsp_valid && !rsp_message_done,
      (rsp_token_count == '0) && !rsp_malformed && !rsp_incomplete_token,
      "message summary fields set on a result that does not end the message")
   `AST_IMPLY(a_payload_nonzero, (mode_ff == MODE_RESP) && (phase_ff == PH_PAYLOAD),
      payload_left_ff != '0, "payload phase entered with no bytes left")
   `AST_IMPLY(a_elements_nonzero, (mode_ff == MODE_RESP) && (phase_ff != PH_COUNT),
      elements_left_ff != '0, "array element phase with no elements left")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import rct_pkg::*;

   localparam int unsigned ELEM_LIMIT   = 65535;
   localparam int unsigned BULK_LIMIT   = 2147483647;
   localparam logic [31:0] ELEM_CAP     = (ELEM_LIMIT < 32'd65535) ? ELEM_LIMIT : 32'd65535;
   localparam int          RANDOM_WORDS = 1730;
   localparam int          QUIET_LIMIT  = 2000;
   localparam int          TAIL_CYCLES  = 10;

   typedef enum logic [1:0] {
      TOK_WAIT_FIRST, TOK_BLANK_SPLIT, TOK_ARRAY, TOK_HALTED
   } tok_mode_type;

   typedef enum logic [2:0] {
      FLD_COUNT, FLD_DOLLAR, FLD_LENGTH, FLD_BODY, FLD_TRAILER
   } fld_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } req_word_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_token_start;
   logic        rsp_token_end;
   logic [15:0] rsp_token_index;
   logic        rsp_message_done;
   logic [15:0] rsp_token_count;
   logic        rsp_malformed;
   logic        rsp_incomplete_token;

   resp_command_tokenizer #(
      .MAX_ELEMENTS    (ELEM_LIMIT),
      .MAX_BULK_LENGTH (BULK_LIMIT)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_byte_valid       (rsp_byte_valid),
      .rsp_token_start      (rsp_token_start),
      .rsp_token_end        (rsp_token_end),
      .rsp_token_index      (rsp_token_index),
      .rsp_message_done     (rsp_message_done),
      .rsp_token_count      (rsp_token_count),
      .rsp_malformed        (rsp_malformed),
      .rsp_incomplete_token (rsp_incomplete_token)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   req_word_type pending_words[$];
   rsp_word_type expected_words[$];
   logic [7:0]   msg_bytes[$];

   int fail_count    = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int msgs_done     = 0;
   int msg_total     = 0;
   int blank_msgs    = 0;
   int array_msgs    = 0;
   int broken_msgs   = 0;
   int noise_msgs    = 0;

   // Tokenizer prediction state.
   tok_mode_type  tk_mode;
   fld_phase_type tk_phase;
   logic [15:0]  elems_left;
   logic [31:0]  num_accum;
   logic         num_seen, num_stopped, num_neg, num_signed, num_cr;
   logic [30:0]  body_left;
   logic [1:0]   trail_left;
   logic [15:0]  tok_idx;
   logic         tok_open;
   logic         bad_field;
   rsp_word_type step_word;
   logic         step_has_word;

   function automatic bit is_blank(logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_VT ||
             c == CHAR_FF || c == CHAR_CR;
   endfunction

   task automatic reset_parser();
      tk_mode     = TOK_WAIT_FIRST;
      tk_phase    = FLD_COUNT;
      elems_left  = '0;
      num_accum   = '0;
      num_seen    = 1'b0;
      num_stopped = 1'b0;
      num_neg     = 1'b0;
      num_signed  = 1'b0;
      num_cr      = 1'b0;
      body_left   = '0;
      trail_left  = '0;
      tok_idx     = '0;
      tok_open    = 1'b0;
      bad_field   = 1'b0;
   endtask

   task automatic put_word(bit has_byte, logic [7:0] b, bit first, bit closing,
                           logic [15:0] idx);
      step_word             = '0;
      step_word.out_byte    = has_byte ? b : 8'h00;
      step_word.byte_valid  = has_byte;
      step_word.token_start = first;
      step_word.token_end   = closing;
      step_word.token_index = idx;
      step_has_word         = 1'b1;
   endtask

   task automatic bump_index();
      if (tok_idx != 16'hFFFF) tok_idx++;
   endtask

   task automatic clear_number();
      num_accum   = '0;
      num_seen    = 1'b0;
      num_stopped = 1'b0;
      num_neg     = 1'b0;
      num_signed  = 1'b0;
      num_cr      = 1'b0;
   endtask

   function automatic void take_field_char(logic [7:0] c);
      logic [63:0] v;
      if (!num_stopped) begin
         if (c >= CHAR_0 && c <= CHAR_9) begin
            v = {32'd0, num_accum} * 64'd10 + {56'd0, c - CHAR_0};
            num_accum = (v > {32'd0, NUM_CAP}) ? NUM_CAP : v[31:0];
            num_seen = 1'b1;
         end else if (!num_seen && !num_signed && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
            num_signed = 1'b1;
            if (c == CHAR_MINUS) num_neg = 1'b1;
         end else if (num_seen || num_signed || !is_blank(c)) begin
            // Leading blanks are skipped; anything else ends the digits.
            num_stopped = 1'b1;
         end
      end
   endfunction

   // Returns 1 on the LF that closes the field.
   function automatic bit field_byte(logic [7:0] b);
      if (num_cr && b == CHAR_LF) begin
         num_cr = 1'b0;
         return 1'b1;
      end
      if (num_cr) begin
         take_field_char(CHAR_CR);
         num_cr = 1'b0;
      end
      if (b == CHAR_CR) num_cr = 1'b1;
      else take_field_char(b);
      return 1'b0;
   endfunction

   function automatic bit field_bad();
      if (!num_seen) return 1'b1;
      return num_neg ? (num_accum > NEG_MAX_MAG) : (num_accum > POS_MAX);
   endfunction

   function automatic bit field_negative();
      return num_neg && num_accum != 0;
   endfunction

   task automatic finish_token();
      bump_index();
      tok_open = 1'b0;
      if (elems_left != 0) elems_left--;
      if (elems_left == 0) begin
         tk_mode = TOK_HALTED;
      end else begin
         tk_phase   = FLD_TRAILER;
         trail_left = 2'd2;
      end
   endtask

   task automatic blank_split_byte(logic [7:0] b, bit last);
      if (is_blank(b)) begin
         if (tok_open) begin
            put_word(1'b0, 8'h00, 1'b0, 1'b1, tok_idx);
            bump_index();
            tok_open = 1'b0;
         end
      end else begin
         put_word(1'b1, b, !tok_open, last, tok_idx);
         tok_open = 1'b1;
         if (last) begin
            bump_index();
            tok_open = 1'b0;
         end
      end
   endtask

   task automatic tokenize_step(logic [7:0] b, bit last);
      step_has_word = 1'b0;
      step_word     = '0;
      case (tk_mode)
         TOK_WAIT_FIRST: begin
            if (b == CHAR_STAR) begin
               tk_mode  = TOK_ARRAY;
               tk_phase = FLD_COUNT;
               clear_number();
            end else begin
               tk_mode = TOK_BLANK_SPLIT;
               blank_split_byte(b, last);
            end
         end
         TOK_BLANK_SPLIT: blank_split_byte(b, last);
         TOK_ARRAY: begin
            case (tk_phase)
               FLD_COUNT: begin
                  if (field_byte(b)) begin
                     if (field_bad()) begin
                        bad_field = 1'b1;
                        tk_mode   = TOK_HALTED;
                     end else if (field_negative() || num_accum == 0) begin
                        tk_mode = TOK_HALTED;
                     end else begin
                        elems_left = (num_accum > ELEM_CAP) ? ELEM_CAP[15:0] : num_accum[15:0];
                        tk_phase   = FLD_DOLLAR;
                     end
                  end
               end
               FLD_DOLLAR: begin
                  if (b == CHAR_DOLLAR) begin
                     clear_number();
                     tk_phase = FLD_LENGTH;
                  end else begin
                     tk_mode = TOK_HALTED;
                  end
               end
               FLD_LENGTH: begin
                  if (field_byte(b)) begin
                     if (field_bad() || (!field_negative() && num_accum > BULK_LIMIT)) begin
                        bad_field = 1'b1;
                        tk_mode   = TOK_HALTED;
                     end else if (field_negative()) begin
                        tk_mode = TOK_HALTED;
                     end else if (num_accum == 0) begin
                        put_word(1'b0, 8'h00, 1'b1, 1'b1, tok_idx);
                        finish_token();
                     end else begin
                        body_left = num_accum[30:0];
                        tok_open  = 1'b0;
                        tk_phase  = FLD_BODY;
                     end
                  end
               end
               FLD_BODY: begin
                  if (body_left != 0) body_left--;
                  put_word(1'b1, b, !tok_open, body_left == 0, tok_idx);
                  tok_open = 1'b1;
                  if (body_left == 0) finish_token();
               end
               FLD_TRAILER: begin
                  if (trail_left != 0) trail_left--;
                  if (trail_left == 0) tk_phase = FLD_DOLLAR;
               end
               default: tk_mode = TOK_HALTED;
            endcase
         end
         default: ;
      endcase

      if (last) begin
         if (!step_has_word) put_word(1'b0, 8'h00, 1'b0, 1'b0, 16'h0000);
         step_word.message_done     = 1'b1;
         step_word.token_count      = tok_idx;
         step_word.malformed        = bad_field;
         step_word.incomplete_token = (tk_mode == TOK_ARRAY) && tok_open;
         reset_parser();
      end
      if (step_has_word) expected_words = {expected_words, step_word};
   endtask

   // Message building.
   task automatic add_byte(logic [7:0] b);
      msg_bytes = {msg_bytes, b};
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic add_crlf();
      add_byte(CHAR_CR);
      add_byte(CHAR_LF);
   endtask

   // Writes a decimal field with random but harmless decoration, then CRLF.
   task automatic add_number(longint v);
      longint mag;
      int     k;
      mag = (v < 0) ? -v : v;
      k = $urandom_range(0, 7);
      if (k == 1) begin
         add_byte(CHAR_SPACE);
      end else if (k == 2) begin
         add_byte(CHAR_TAB);
         add_byte(CHAR_SPACE);
      end
      if (v < 0) add_byte(CHAR_MINUS);
      else if ($urandom_range(0, 5) == 0) add_byte(CHAR_PLUS);
      if ($urandom_range(0, 5) == 0) add_text("00");
      add_text($sformatf("%0d", mag));
      k = $urandom_range(0, 9);
      if (k == 0) begin
         add_byte(CHAR_SPACE);
      end else if (k == 1) begin
         add_text("z9");
      end else if (k == 2) begin
         // A lone CR inside the field is just another field byte.
         add_byte(CHAR_CR);
         add_text("q");
      end
      add_crlf();
   endtask

   task automatic add_blanks();
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 5))
            0: add_byte(CHAR_SPACE);
            1: add_byte(CHAR_TAB);
            2: add_byte(CHAR_LF);
            3: add_byte(CHAR_VT);
            4: add_byte(CHAR_FF);
            default: add_byte(CHAR_CR);
         endcase
      end
   endtask

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] random_nonblank();
      logic [7:0] b;
      do b = random_byte(); while (is_blank(b));
      return b;
   endfunction

   // Moves the message into the pending words; keep > 0 cuts it short.
   task automatic flush_message(int keep);
      int           n;
      req_word_type w;
      n = (keep > 0 && keep < msg_bytes.size()) ? keep : msg_bytes.size();
      for (int i = 0; i < n; i++) begin
         w.data = msg_bytes[i];
         w.last = (i == n - 1);
         pending_words = {pending_words, w};
      end
      msg_bytes.delete();
      msg_total++;
   endtask

   // Idle stretches: while calm is set, neither side inserts gaps or stalls.
   logic calm      = 1'b0;
   int   calm_left = 0;

   always @(posedge clock) begin
      if (calm_left > 0) begin
         calm_left--;
      end else begin
         calm <= ($urandom_range(0, 3) == 0);
         calm_left = $urandom_range(100, 400);
      end
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Driver.
   int           gap_left = 0;
   req_word_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         reset_parser();
      end else begin
         if (req_valid && !req_stall) begin
            tokenize_step(req_data_byte, req_last_byte);
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left--;
            end else if (pending_words.size() > 0) begin
               next_req = pending_words.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= next_req.data;
               req_last_byte <= next_req.last;
               gap_left = idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor.
   int           stall_left = 0;
   rsp_word_type seen_word;
   rsp_word_type want_word;

   function automatic string word_text(rsp_word_type w);
      return $sformatf({"byte=%02h bv=%0d start=%0d end=%0d idx=%0d",
                        " done=%0d cnt=%0d mal=%0d inc=%0d"},
                       w.out_byte, w.byte_valid, w.token_start, w.token_end, w.token_index,
                       w.message_done, w.token_count, w.malformed, w.incomplete_token);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_word = {rsp_out_byte, rsp_byte_valid, rsp_token_start, rsp_token_end,
                         rsp_token_index, rsp_message_done, rsp_token_count,
                         rsp_malformed, rsp_incomplete_token};
            words_checked++;
            if (seen_word.message_done === 1'b1) msgs_done++;
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word %0d: %s", words_checked, word_text(seen_word));
            end else begin
               want_word = expected_words.pop_front();
               if (seen_word !== want_word) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result word %0d differs\n  expected %s\n  actual   %s",
                              words_checked, word_text(want_word), word_text(seen_word));
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            stall_left = idle_len();
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // Watchdog on cycles where no word moves on either side.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_words.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int         kind;
      int         sub;
      int         n;
      int         len;
      int         base;
      longint     lv;
      logic [7:0] b;

      // Directed messages: a lone byte, a token closed by a blank with a blank
      // as last byte, a bare star, a zero-length element, and a cut payload.
      add_byte(8'h00);
      flush_message(0);
      add_byte(8'hFF);
      add_byte(CHAR_SPACE);
      add_byte(CHAR_TAB);
      flush_message(0);
      add_byte(CHAR_STAR);
      flush_message(0);
      add_text("*1");
      add_crlf();
      add_text("$0");
      add_crlf();
      flush_message(0);
      add_text("*1");
      add_crlf();
      add_text("$3");
      add_crlf();
      add_text("ab");
      flush_message(0);

      base = pending_words.size();
      while (pending_words.size() - base < RANDOM_WORDS) begin
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            blank_msgs++;
            n = $urandom_range(1, 5);
            if ($urandom_range(0, 3) == 0) add_blanks();
            for (int t = 0; t < n; t++) begin
               len = $urandom_range(1, 6);
               repeat (len) add_byte(random_nonblank());
               if (t < n - 1 || $urandom_range(0, 1) == 1) add_blanks();
            end
            flush_message(0);
         end else if (kind < 70) begin
            array_msgs++;
            n = $urandom_range(1, 4);
            add_byte(CHAR_STAR);
            add_number(longint'(n));
            for (int e = 0; e < n; e++) begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
               add_byte(CHAR_DOLLAR);
               add_number(longint'(len));
               repeat (len) add_byte(random_byte());
               if ($urandom_range(0, 4) != 0) add_crlf();
               else repeat (2) add_byte(random_byte());
            end
            repeat ($urandom_range(0, 3)) add_byte(random_byte());
            flush_message(($urandom_range(0, 3) == 0) ? $urandom_range(1, msg_bytes.size()) : 0);
         end else if (kind < 90) begin
            broken_msgs++;
            add_byte(CHAR_STAR);
            sub = $urandom_range(0, 9);
            case (sub)
               0: add_number(0);
               1: begin
                  lv = longint'($urandom_range(1, 9));
                  if ($urandom_range(0, 3) == 0) add_number(-64'sd2147483648);
                  else add_number(-lv);
               end
               2: begin
                  // A field with no digits, in the count or in a length.
                  if ($urandom_range(0, 1) == 1) begin
                     add_number(1);
                     add_byte(CHAR_DOLLAR);
                  end
                  case ($urandom_range(0, 3))
                     0: ;
                     1: add_byte(CHAR_PLUS);
                     2: begin
                        add_byte(CHAR_SPACE);
                        add_byte(CHAR_MINUS);
                        add_text("x");
                     end
                     default: add_text("x5");
                  endcase
                  add_crlf();
               end
               3: begin
                  if ($urandom_range(0, 1) == 1) begin
                     add_number(1);
                     add_byte(CHAR_DOLLAR);
                  end
                  case ($urandom_range(0, 2))
                     0: add_number(64'sd2147483648);
                     1: add_number(64'sd99999999999);
                     default: add_number(-64'sd2147483649);
                  endcase
               end
               4: begin
                  // Count above the element ceiling.
                  if ($urandom_range(0, 1) == 1) add_number(70000);
                  else add_number(64'sd2147483647);
                  add_byte(CHAR_DOLLAR);
                  add_number(1);
                  add_byte(random_byte());
                  add_crlf();
               end
               5: begin
                  add_number(2);
                  if ($urandom_range(0, 1) == 1) begin
                     add_text("$1");
                     add_crlf();
                     add_byte(random_byte());
                     add_crlf();
                  end
                  do b = random_byte(); while (b == CHAR_DOLLAR);
                  add_byte(b);
               end
               6: begin
                  add_number(1);
                  add_byte(CHAR_DOLLAR);
                  lv = longint'($urandom_range(1, 100));
                  add_number(-lv);
               end
               7: begin
                  // Largest legal length; the message ends inside the payload.
                  add_number(1);
                  add_byte(CHAR_DOLLAR);
                  add_number(longint'(BULK_LIMIT));
                  repeat ($urandom_range(1, 5)) add_byte(random_byte());
               end
               8: begin
                  // Ends right after the length, before any payload byte.
                  add_number(longint'($urandom_range(1, 3)));
                  add_byte(CHAR_DOLLAR);
                  add_number(longint'($urandom_range(1, 9)));
               end
               default: begin
                  add_number(2);
                  add_byte(CHAR_DOLLAR);
                  add_number(0);
                  add_crlf();
                  add_byte(CHAR_DOLLAR);
                  add_number(0);
               end
            endcase
            if (sub < 7) repeat ($urandom_range(0, 4)) add_byte(random_byte());
            flush_message(0);
         end else begin
            noise_msgs++;
            if ($urandom_range(0, 1) == 1) add_byte(CHAR_STAR);
            repeat ($urandom_range(1, 12)) add_byte(random_byte());
            flush_message(0);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d messages: %0d blank-split, %0d array, %0d broken, %0d noise,",
               msg_total, blank_msgs, array_msgs, broken_msgs, noise_msgs);
      $display("plus directed ones; %0d words in, %0d checked, %0d ends seen, %0d errors.",
               words_sent, words_checked, msgs_done, fail_count);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/rct_pkg.sv
rtl/core/rct_num_field.sv
rtl/core/resp_command_tokenizer.sv
tb/sv/tb_top.sv
